### hw/rtl/pns_pkg.sv
`default_nettype none

package pns_pkg;

    localparam int DIM_W          = 13;
    localparam int COORD_W        = 12;
    localparam int IDX_W          = 16;
    localparam int PIX_W          = 8;
    localparam int CHAN_W         = 7;
    localparam int APB_AW         = 3;
    localparam int APB_DW         = 32;
    localparam int DIM_MAX        = 4096;
    localparam int OUT_WIDTH_RST  = 640;
    localparam int OUT_HEIGHT_RST = 480;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RATIO,
        ST_BAND,
        ST_COLUMN,
        ST_ROW,
        ST_READ,
        ST_PAL,
        ST_BLACK
    } pns_state_t;

    typedef enum logic {
        REQ_WRITE = 1'b0,
        REQ_FETCH = 1'b1
    } pns_req_t;

    typedef enum logic {
        REG_OUT_WIDTH  = 1'b0,
        REG_OUT_HEIGHT = 1'b1
    } pns_reg_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pns_div_stat_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } pns_rgb_t;

    function automatic logic [DIM_W-1:0] pns_clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
        begin
            r = DIM_W'(1);
        end
        else if (v > DIM_W'(DIM_MAX))
        begin
            r = DIM_W'(DIM_MAX);
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

    // blue-to-white ramp fading back to black, black from 192 up; each channel clamped to 255 and halved
    function automatic pns_rgb_t pns_ramp(input logic [PIX_W-1:0] v);
        pns_rgb_t c;
        logic [PIX_W-1:0] k;
        c = '0;
        k = {2'b00, v[5:0]};
        case (v[7:6])
            2'b00:
            begin
                c.blue = {v[5:0], 1'b0};
            end
            2'b01:
            begin
                c.red   = k[CHAN_W-1:0];
                c.green = k[CHAN_W-1:0];
                c.blue  = (k == '0) ? 7'd127 : CHAN_W'(8'd128 - k);
            end
            2'b10:
            begin
                c.red   = (k == '0) ? 7'd127 : CHAN_W'(8'd128 - {k[6:0], 1'b0});
                c.green = c.red;
                c.blue  = CHAN_W'(8'd64 - k);
            end
            default:
            begin
                c = '0;
            end
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/pns_req_if.sv
`default_nettype none

interface pns_req_if import pns_pkg::*; ();
    logic               valid;
    logic               ready;
    logic               req_type;
    logic [IDX_W-1:0]   src_index;
    logic [PIX_W-1:0]   src_value;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;

    modport source (
        output valid,
        output req_type,
        output src_index,
        output src_value,
        output out_x,
        output out_y,
        input  ready
    );

    modport sink (
        input  valid,
        input  req_type,
        input  src_index,
        input  src_value,
        input  out_x,
        input  out_y,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/pns_res_if.sv
`default_nettype none

interface pns_res_if import pns_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              in_band;

    modport source (
        output valid,
        output red,
        output green,
        output blue,
        output in_band,
        input  ready
    );

    modport sink (
        input  valid,
        input  red,
        input  green,
        input  blue,
        input  in_band,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/pns_ram.sv
`default_nettype none

module pns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64000
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### hw/rtl/pns_div.sv
`default_nettype none

module pns_div import pns_pkg::*; #(
    parameter int DVD_W = 22,
    parameter int DVS_W = 13
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic      [DVD_W-1:0] quotient,
    output pns_div_stat_t         stat
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [DVS_W:0]   shifted;
    logic [DVS_W+1:0] diff;

    // one quotient bit per cycle, restoring
    always_comb
    begin
        shifted   = {rem_reg, quo_reg[DVD_W-1]};
        diff      = {1'b0, shifted} - {2'b00, dvs_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
            cnt_next  = CNT_W'(DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[DVS_W+1])
            begin
                rem_next = diff[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[DVS_W-1:0];
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");

    a_busy_count: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with no steps left");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("divider done held");

endmodule

`default_nettype wire

### hw/rtl/palette_nearest_scaler.sv
`default_nettype none

// Letterboxing nearest-neighbour scaler over an 8-bit indexed source image held in
// one SRC_WIDTH x SRC_HEIGHT byte RAM, with a fixed blue-to-white ramp palette giving
// 7-bit channels. A write word stores one source pixel and gives no result; an index
// beyond the image is dropped. A fetch word gives one result and is worked on alone.
// The band height comes from a multiply by the constant ratio SRC_HEIGHT / SRC_WIDTH,
// registered in ST_RATIO. Column and row then run in turn through one shared radix-2
// divider of DVD_W = 13 + clog2(max(SRC_WIDTH, SRC_HEIGHT) + 1) steps. An in-band
// fetch passes ST_RATIO, ST_BAND, ST_COLUMN, ST_ROW, ST_READ and ST_PAL; a letterbox
// row leaves ST_BAND for ST_BLACK, and a pixel outside the configured size goes from
// ST_IDLE straight to ST_BLACK. A result still held by the sink stalls the fetch
// behind it. After reset the RAM is swept to zero, during which no word is taken;
// register writes are taken at any time. Registers: out_width at 0x0, out_height at
// 0x4; of bits 12:0 written, 0 reads back as 1 and above 4096 as 4096.

module palette_nearest_scaler import pns_pkg::*; #(
    parameter int SRC_WIDTH  = 320,
    parameter int SRC_HEIGHT = 200
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    pns_req_if.sink                req,
    pns_res_if.source              res,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic      [APB_DW-1:0] prdata,
    output logic                   pready
);

    localparam int     DEPTH   = SRC_WIDTH * SRC_HEIGHT;
    localparam int     AW      = $clog2(DEPTH);
    localparam int     SRC_MAX = (SRC_WIDTH > SRC_HEIGHT) ? SRC_WIDTH : SRC_HEIGHT;
    localparam int     DVD_W   = DIM_W + $clog2(SRC_MAX + 1);
    localparam int     DVS_W   = DIM_W;
    localparam int     SXW     = $clog2(SRC_WIDTH);
    localparam int     SYW     = $clog2(SRC_HEIGHT);
    localparam int     RCP_SH  = DIM_W + $clog2(SRC_WIDTH);
    localparam longint RCP_M   = ((longint'(SRC_HEIGHT) << RCP_SH) + longint'(SRC_WIDTH) - 1) /
                                 longint'(SRC_WIDTH);
    localparam int     RCP_W   = $clog2(RCP_M + 1);
    localparam int     PROD_W  = DIM_W + RCP_W;

    pns_state_t        state_reg, state_next;
    logic [AW-1:0]     clr_cnt_reg, clr_cnt_next;
    logic [DIM_W-1:0]  out_width_reg, out_width_next;
    logic [DIM_W-1:0]  out_height_reg, out_height_next;
    logic              res_valid_reg, res_valid_next;

    logic [COORD_W-1:0] x_reg, x_next;
    logic [COORD_W-1:0] y_reg, y_next;
    logic [DIM_W-1:0]   off_reg, off_next;
    logic [DIM_W-1:0]   h_reg, h_next;
    logic [SXW-1:0]     sx_reg, sx_next;
    logic [AW-1:0]      addr_reg, addr_next;
    pns_rgb_t           rgb_reg, rgb_next;
    logic               band_reg, band_next;

    logic              req_fire;
    logic              fetch_fire;
    logic              in_size;
    logic              idx_ok;
    logic [31:0]       idx_ext;
    logic              cfg_write;
    logic              res_free;
    logic              res_load;
    logic [DIM_W-1:0]  h_comb;
    logic [DIM_W-1:0]  y_ext;
    logic              band_ok;
    logic [PROD_W-1:0] ratio_prod;
    logic [DVD_W-1:0]  q_ext;
    logic [DVD_W-1:0]  yr_ext;
    logic [SXW-1:0]    sx_clamp;
    logic [SYW-1:0]    sy_clamp;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [PIX_W-1:0]  ram_wdata;
    logic [PIX_W-1:0]  ram_rdata;

    logic              div_start;
    logic [DVD_W-1:0]  div_dividend;
    logic [DVS_W-1:0]  div_divisor;
    logic [DVD_W-1:0]  div_quo;
    pns_div_stat_t     div_stat;

    pns_ram #(
        .WIDTH (PIX_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    pns_div #(
        .DVD_W (DVD_W),
        .DVS_W (DVS_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    assign req_fire   = req.valid && req.ready;
    assign fetch_fire = req_fire && (req.req_type == REQ_FETCH);
    assign in_size    = ({1'b0, req.out_x} < out_width_reg) &&
                        ({1'b0, req.out_y} < out_height_reg);
    assign idx_ext    = 32'(req.src_index);
    assign idx_ok     = idx_ext < 32'(DEPTH);
    assign cfg_write  = psel && penable && pwrite && pready;
    assign res_free   = !res_valid_reg || res.ready;

    // band geometry
    assign ratio_prod = PROD_W'(out_width_reg) * PROD_W'(RCP_M);
    assign q_ext   = DVD_W'(ratio_prod >> RCP_SH);
    assign yr_ext  = DVD_W'(out_height_reg);
    assign h_comb  = out_height_reg - (off_reg << 1);
    assign y_ext   = DIM_W'(y_reg);
    assign band_ok = (h_comb != '0) && (y_ext >= off_reg) &&
                     (y_ext < (out_height_reg - off_reg));

    // source coordinates clamped to the last column and row
    assign sx_clamp = (div_quo >= DVD_W'(SRC_WIDTH)) ? SXW'(SRC_WIDTH - 1) :
                      div_quo[SXW-1:0];
    assign sy_clamp = (div_quo >= DVD_W'(SRC_HEIGHT)) ? SYW'(SRC_HEIGHT - 1) :
                      div_quo[SYW-1:0];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == AW'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (fetch_fire)
                begin
                    state_next = in_size ? ST_RATIO : ST_BLACK;
                end
            end
            ST_RATIO:
            begin
                state_next = ST_BAND;
            end
            ST_BAND:
            begin
                state_next = band_ok ? ST_COLUMN : ST_BLACK;
            end
            ST_COLUMN:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_ROW;
                end
            end
            ST_ROW:
            begin
                if (div_stat.done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_PAL;
            end
            ST_PAL, ST_BLACK:
            begin
                if (res_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready    = 1'b0;
        ram_we       = 1'b0;
        ram_waddr    = idx_ext[AW-1:0];
        ram_wdata    = req.src_value;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        res_load     = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
                ram_we    = req_fire && (req.req_type == REQ_WRITE) && idx_ok;
            end
            ST_BAND:
            begin
                div_start    = band_ok;
                div_dividend = DVD_W'(x_reg) * DVD_W'(SRC_WIDTH);
                div_divisor  = out_width_reg;
            end
            ST_COLUMN:
            begin
                div_start    = div_stat.done;
                div_dividend = DVD_W'(y_ext - off_reg) * DVD_W'(SRC_HEIGHT);
                div_divisor  = h_reg;
            end
            ST_PAL, ST_BLACK:
            begin
                res_load = res_free;
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        clr_cnt_next    = clr_cnt_reg;
        out_width_next  = out_width_reg;
        out_height_next = out_height_reg;
        res_valid_next  = res_valid_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        off_next        = off_reg;
        h_next          = h_reg;
        sx_next         = sx_reg;
        addr_next       = addr_reg;
        rgb_next        = rgb_reg;
        band_next       = band_reg;

        if (state_reg == ST_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + AW'(1);
        end

        if (cfg_write)
        begin
            case (pns_reg_t'(paddr[2]))
                REG_OUT_WIDTH:  out_width_next  = pns_clamp_dim(pwdata[DIM_W-1:0]);
                REG_OUT_HEIGHT: out_height_next = pns_clamp_dim(pwdata[DIM_W-1:0]);
                default:        out_width_next  = out_width_reg;
            endcase
        end

        if (fetch_fire)
        begin
            x_next = req.out_x;
            y_next = req.out_y;
        end

        if (state_reg == ST_RATIO)
        begin
            off_next = (yr_ext > q_ext) ? DIM_W'((yr_ext - q_ext) >> 1) : '0;
        end

        if (state_reg == ST_BAND)
        begin
            h_next = h_comb;
        end

        if (state_reg == ST_COLUMN && div_stat.done)
        begin
            sx_next = sx_clamp;
        end

        if (state_reg == ST_ROW && div_stat.done)
        begin
            addr_next = AW'(AW'(sy_clamp) * AW'(SRC_WIDTH)) + AW'(sx_reg);
        end

        if (res_load)
        begin
            if (state_reg == ST_PAL)
            begin
                rgb_next  = pns_ramp(ram_rdata);
                band_next = 1'b1;
            end
            else
            begin
                rgb_next  = '0;
                band_next = 1'b0;
            end
            res_valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            out_width_reg  <= DIM_W'(OUT_WIDTH_RST);
            out_height_reg <= DIM_W'(OUT_HEIGHT_RST);
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            out_width_reg  <= out_width_next;
            out_height_reg <= out_height_next;
            res_valid_reg  <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg    <= x_next;
        y_reg    <= y_next;
        off_reg  <= off_next;
        h_reg    <= h_next;
        sx_reg   <= sx_next;
        addr_reg <= addr_next;
        rgb_reg  <= rgb_next;
        band_reg <= band_next;
    end

    always_comb
    begin
        case (pns_reg_t'(paddr[2]))
            REG_OUT_WIDTH:  prdata = APB_DW'(out_width_reg);
            REG_OUT_HEIGHT: prdata = APB_DW'(out_height_reg);
            default:        prdata = '0;
        endcase
    end

    assign pready      = 1'b1;
    assign res.valid   = res_valid_reg;
    assign res.red     = rgb_reg.red;
    assign res.green   = rgb_reg.green;
    assign res.blue    = rgb_reg.blue;
    assign res.in_band = band_reg;

    a_no_store_mid_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE && state_reg != ST_CLEAR) |-> !ram_we)
        else $error("pixel store written during a fetch");

    a_letterbox_black: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && !res.in_band) |->
            (res.red == '0 && res.green == '0 && res.blue == '0))
        else $error("letterbox word not black");

    a_pal_after_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAL) |->
            ($past(state_reg) == ST_READ || $past(state_reg) == ST_PAL))
        else $error("palette stage without a store read");

    a_div_running: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_COLUMN || state_reg == ST_ROW) |->
            (div_stat.busy || div_stat.done))
        else $error("waiting on an idle divider");

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
    import pns_pkg::*;

    localparam int SRC_W       = 320;
    localparam int SRC_H       = 200;
    localparam int IMAGE_DEPTH = SRC_W * SRC_H;
    localparam int SETTLE      = 80;
    localparam int LONG_HOLD   = 600;
    localparam int PHASE_WORDS = 75;

    typedef struct packed {
        pns_req_t           kind;
        logic [IDX_W-1:0]   index;
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } pixel_req_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              in_band;
    } pixel_rgb_t;

    typedef struct packed {
        pixel_req_t word;
        logic       typed;
        pixel_rgb_t want;
    } directed_row_t;

    // default size 640 x 480: band rows 40..439, source pixel 0 sits at (0, 40)
    localparam directed_row_t DIRECTED [24] = '{
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd0,    12'd0},    1'b1, '{7'd0,   7'd0,   7'd0,   1'b0}},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd639,  12'd479},  1'b1, '{7'd0,   7'd0,   7'd0,   1'b0}},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd640,  12'd100},  1'b1, '{7'd0,   7'd0,   7'd0,   1'b0}},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd4095, 12'd4095}, 1'b1, '{7'd0,   7'd0,   7'd0,   1'b0}},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd320,  12'd240},  1'b1, '{7'd0,   7'd0,   7'd0,   1'b1}},
        '{'{REQ_WRITE, 16'd0,     8'd255, 12'd0,    12'd0},    1'b0, '0},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd0,    12'd40},   1'b1, '{7'd0,   7'd0,   7'd0,   1'b1}},
        '{'{REQ_WRITE, 16'd0,     8'd63,  12'd0,    12'd0},    1'b0, '0},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd0,    12'd40},   1'b1, '{7'd0,   7'd0,   7'd126, 1'b1}},
        '{'{REQ_WRITE, 16'd0,     8'd64,  12'd0,    12'd0},    1'b0, '0},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd0,    12'd40},   1'b1, '{7'd0,   7'd0,   7'd127, 1'b1}},
        '{'{REQ_WRITE, 16'd0,     8'd127, 12'd0,    12'd0},    1'b0, '0},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd0,    12'd40},   1'b1, '{7'd63,  7'd63,  7'd65,  1'b1}},
        '{'{REQ_WRITE, 16'd0,     8'd128, 12'd0,    12'd0},    1'b0, '0},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd0,    12'd40},   1'b1, '{7'd127, 7'd127, 7'd64,  1'b1}},
        '{'{REQ_WRITE, 16'd0,     8'd191, 12'd0,    12'd0},    1'b0, '0},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd0,    12'd40},   1'b1, '{7'd2,   7'd2,   7'd1,   1'b1}},
        '{'{REQ_WRITE, 16'd63999, 8'd100, 12'd0,    12'd0},    1'b0, '0},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd639,  12'd439},  1'b0, '0},
        '{'{REQ_WRITE, 16'd64000, 8'd50,  12'd0,    12'd0},    1'b0, '0},
        '{'{REQ_WRITE, 16'd65535, 8'd200, 12'd0,    12'd0},    1'b0, '0},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd639,  12'd439},  1'b0, '0},
        '{'{REQ_WRITE, 16'd0,     8'd1,   12'd0,    12'd0},    1'b0, '0},
        '{'{REQ_FETCH, 16'd0,     8'd0,   12'd1,    12'd40},   1'b0, '0}
    };

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    pns_req_if req ();
    pns_res_if res ();

    palette_nearest_scaler #(
        .SRC_WIDTH  (SRC_W),
        .SRC_HEIGHT (SRC_H)
    ) DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .res     (res),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    logic [PIX_W-1:0] src_image [IMAGE_DEPTH];
    pixel_rgb_t       pixel_q [$];
    int               fb_w = OUT_WIDTH_RST;
    int               fb_h = OUT_HEIGHT_RST;
    int               errors = 0;
    int               hold_cycles = 0;
    bit               calm = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    task automatic report(input string what);
        errors++;
        if (errors <= 100)
        begin
            $display("mismatch at %0t: %s", $time, what);
        end
    endtask

    function automatic int halve(input int c);
        if (c > 255)
        begin
            c = 255;
        end
        if (c < 0)
        begin
            c = 0;
        end
        return c >> 1;
    endfunction

    // letterbox and nearest-neighbour mapping; 0 when the pixel is black
    function automatic bit source_address(input int x, input int y, output int addr);
        int q;
        int off;
        int band_h;
        int sx;
        int sy;
        addr = 0;
        q = fb_w * SRC_H / SRC_W;
        off = (fb_h > q) ? (fb_h - q) / 2 : 0;
        band_h = fb_h - 2 * off;
        if (x >= fb_w || y >= fb_h || band_h == 0 || y < off || y >= fb_h - off)
        begin
            return 1'b0;
        end
        sy = (y - off) * SRC_H / band_h;
        if (sy >= SRC_H)
        begin
            sy = SRC_H - 1;
        end
        sx = x * SRC_W / fb_w;
        if (sx >= SRC_W)
        begin
            sx = SRC_W - 1;
        end
        addr = sy * SRC_W + sx;
        return 1'b1;
    endfunction

    function automatic pixel_rgb_t expected_pixel(input int x, input int y);
        pixel_rgb_t p;
        int addr;
        int v;
        int grey;
        int blue;
        p = '0;
        if (!source_address(x, y, addr))
        begin
            return p;
        end
        v = src_image[addr];
        grey = 0;
        blue = 0;
        if (v < 64)
        begin
            blue = 4 * v;
        end
        else if (v < 128)
        begin
            grey = (v - 64) * 2;
            blue = 256 - (v - 64) * 2;
        end
        else if (v < 192)
        begin
            grey = 256 - (v - 128) * 4;
            blue = 256 - (v - 64) * 2;
        end
        p.red     = CHAN_W'(halve(grey));
        p.green   = CHAN_W'(halve(grey));
        p.blue    = CHAN_W'(halve(blue));
        p.in_band = 1'b1;
        return p;
    endfunction

    task automatic send_word(input pixel_req_t w, input bit typed = 1'b0,
                             input pixel_rgb_t typed_want = '0);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.req_type  <= w.kind;
        req.src_index <= w.index;
        req.src_value <= w.value;
        req.out_x     <= w.x;
        req.out_y     <= w.y;
        do @(posedge clk); while (!req.ready);
        if (w.kind == REQ_WRITE)
        begin
            if (w.index < IMAGE_DEPTH)
            begin
                src_image[w.index] = w.value;
            end
        end
        else
        begin
            pixel_q.push_back(typed ? typed_want : expected_pixel(w.x, w.y));
        end
    endtask

    task automatic wait_drained();
        req.valid <= 1'b0;
        while (pixel_q.size() != 0) @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input pns_reg_t sel, input logic [APB_DW-1:0] data);
        logic [DIM_W-1:0] dim;
        dim = data[DIM_W-1:0];
        if (dim == '0)
        begin
            dim = DIM_W'(1);
        end
        else if (dim > DIM_W'(DIM_MAX))
        begin
            dim = DIM_W'(DIM_MAX);
        end
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'({sel, 2'b00});
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_OUT_WIDTH)
        begin
            fb_w = int'(dim);
        end
        else
        begin
            fb_h = int'(dim);
        end
        @(posedge clk);
        psel   <= 1'b1;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata !== APB_DW'(dim))
        begin
            report($sformatf("register %s read %0d want %0d", sel.name(), prdata, dim));
        end
    endtask

    // source writes each followed by a fetch that lands on it, mixed with lone fetches and writes
    task automatic random_words(input int count);
        pixel_req_t w;
        pixel_req_t wr;
        int addr;
        int pick;
        int done;
        done = 0;
        while (done < count)
        begin
            w.kind  = REQ_FETCH;
            w.index = IDX_W'($urandom);
            w.value = PIX_W'($urandom);
            w.x     = COORD_W'($urandom);
            w.y     = COORD_W'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 70)
            begin
                w.x = COORD_W'($urandom_range(0, fb_w - 1));
                w.y = COORD_W'($urandom_range(0, fb_h - 1));
                if (pick < 45 && source_address(w.x, w.y, addr))
                begin
                    wr = w;
                    wr.kind  = REQ_WRITE;
                    wr.index = IDX_W'(addr);
                    wr.value = PIX_W'($urandom);
                    send_word(wr);
                    done++;
                end
            end
            else if (pick >= 78)
            begin
                w.kind = REQ_WRITE;
                if (pick < 94)
                begin
                    w.index = IDX_W'($urandom_range(0, IMAGE_DEPTH - 1));
                end
            end
            send_word(w);
            if (!(w.kind == REQ_WRITE && w.index >= IMAGE_DEPTH))
            begin
                done++;
            end
        end
    endtask

    initial
    begin : result_sink
        int stall;
        res.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                stall = hold_cycles;
                hold_cycles = 0;
            end
            else
            begin
                stall = calm ? 0 : $urandom_range(0, 4);
            end
            if (stall > 0)
            begin
                res.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res.ready <= 1'b1;
            do @(posedge clk); while (!res.valid);
        end
    end

    always @(posedge clk)
    begin : result_check
        pixel_rgb_t got;
        pixel_rgb_t want;
        if (rst_n && res.valid && res.ready)
        begin
            got = {res.red, res.green, res.blue, res.in_band};
            if (pixel_q.size() == 0)
            begin
                report($sformatf("unexpected pixel r=%0d g=%0d b=%0d band=%0d",
                                 got.red, got.green, got.blue, got.in_band));
            end
            else
            begin
                want = pixel_q.pop_front();
                if (got !== want)
                begin
                    report($sformatf("pixel r=%0d g=%0d b=%0d band=%0d want %0d %0d %0d %0d",
                                     got.red, got.green, got.blue, got.in_band,
                                     want.red, want.green, want.blue, want.in_band));
                end
            end
        end
    end

    initial
    begin : stimulus
        logic [APB_DW-1:0] sizes [9][2];
        logic [APB_DW-1:0] w_set;
        logic [APB_DW-1:0] h_set;
        sizes = '{
            '{32'd0,          32'd0},
            '{32'd1,          32'd4096},
            '{32'hFFFF_FFFF,  32'h0000_1FFF},
            '{32'd4096,       32'd4096},
            '{32'd320,        32'd200},
            '{32'd100,        32'd600},
            '{32'd700,        32'd100},
            '{32'd4096,       32'd1},
            '{32'h0001_0003,  32'h0000_2005}
        };
        for (int i = 0; i < IMAGE_DEPTH; i++)
        begin
            src_image[i] = '0;
        end
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        req.valid     <= 1'b0;
        req.req_type  <= REQ_WRITE;
        req.src_index <= '0;
        req.src_value <= '0;
        req.out_x     <= '0;
        req.out_y     <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED[i])
        begin
            send_word(DIRECTED[i].word, DIRECTED[i].typed, DIRECTED[i].want);
        end
        wait_drained();

        for (int phase = 0; phase < 15; phase++)
        begin
            if (phase < 9)
            begin
                w_set = sizes[phase][0];
                h_set = sizes[phase][1];
            end
            else
            begin
                w_set = APB_DW'($urandom_range(1, DIM_MAX));
                h_set = APB_DW'($urandom_range(1, DIM_MAX));
            end
            write_reg(REG_OUT_WIDTH, w_set);
            write_reg(REG_OUT_HEIGHT, h_set);
            calm = (phase % 4 == 3);
            if (phase == 4)
            begin
                hold_cycles = LONG_HOLD;
            end
            random_words(PHASE_WORDS);
            wait_drained();
        end

        if (errors == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
